>>> src/cdl_pkg.sv
// shared constants, types and constant tables of the slope/offset/power grade
package cdl_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int LOG_TABLE_ADDR_BITS = 10;
    localparam int NUM_LANES           = 3;
    localparam int COEF_W              = 16;
    localparam int CFG_W               = NUM_LANES * COEF_W;
    localparam int CFG_IDX_W           = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_UNITY = {NUM_LANES{16'h1000}};

    localparam int FRAC       = SAMPLE_BITS - 1;
    localparam int COEF_FRAC  = 12;
    localparam int LOG_FRAC   = 16;
    localparam int MANT       = 30;
    localparam int REM_BITS   = MANT - LOG_TABLE_ADDR_BITS;
    localparam int LOG_NODES  = 1 << LOG_TABLE_ADDR_BITS;
    localparam int DL_W       = LOG_FRAC + 1;
    localparam int LOG_ENT_W  = LOG_FRAC + DL_W;
    localparam int PROD_W     = SAMPLE_BITS + COEF_W;
    localparam int B_W        = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int E_W        = $clog2(B_W);
    localparam int MSH_W      = B_W + MANT;
    localparam int IP_W       = DL_W + REM_BITS;
    localparam int LG_W       = LOG_FRAC + 8;
    localparam int LP_W       = LG_W + COEF_W + 1;
    localparam int T_W        = LP_W - COEF_FRAC;
    localparam int N_W        = T_W - LOG_FRAC;
    localparam int SHF_W      = N_W + 2;
    localparam int Y_W        = MANT + 1;
    localparam int SH_W       = $clog2(Y_W + 1);
    localparam int RS_W       = Y_W + 2;
    localparam int EXP_STEPS  = LOG_FRAC;

    localparam logic [SAMPLE_BITS-1:0] ONE_SAMPLE = SAMPLE_BITS'(1) << FRAC;
    localparam logic [Y_W-1:0]         ONE_MANT   = Y_W'(1) << MANT;

    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_ONE  = 2'd1,
        MODE_CALC = 2'd2
    } t_mode;

    typedef struct packed {
        logic                   valid;
        logic [SAMPLE_BITS-1:0] value;
    } t_lane_out;

    typedef logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] t_pixel;

    typedef logic [LOG_ENT_W-1:0] t_log_rom [LOG_NODES];
    typedef logic [Y_W-1:0]       t_roots   [EXP_STEPS];

    // log2 of a Q1.30 mantissa in [1,2] by repeated squaring
    function automatic logic [LOG_FRAC:0] mant_log2(input logic [63:0] m_in);
        logic [63:0]       m;
        logic [LOG_FRAC:0] r;
        m = m_in;
        r = '0;
        if (m >= (64'd2 << MANT)) begin
            return (LOG_FRAC+1)'(1) << LOG_FRAC;
        end
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> MANT;
            r = r << 1;
            if (m >= (64'd2 << MANT)) begin
                m    = m >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    // each entry: node value and distance to the next node
    function automatic t_log_rom build_log_rom();
        t_log_rom          rom;
        logic [LOG_FRAC:0] l0;
        logic [LOG_FRAC:0] l1;
        for (int k = 0; k < LOG_NODES; k++) begin
            l0 = mant_log2((64'd1 << MANT) + (64'(k) << REM_BITS));
            l1 = mant_log2((64'd1 << MANT) + (64'(k + 1) << REM_BITS));
            rom[k] = {l0[LOG_FRAC-1:0], DL_W'(l1 - l0)};
        end
        return rom;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // successive square roots of 2.0 in Q1.30
    function automatic t_roots build_roots();
        t_roots      roots;
        logic [63:0] root;
        root = 64'd2 << MANT;
        for (int k = 0; k < EXP_STEPS; k++) begin
            root     = int_sqrt(root << MANT);
            roots[k] = Y_W'(root);
        end
        return roots;
    endfunction

    localparam t_log_rom LOG_ROM   = build_log_rom();
    localparam t_roots   EXP_ROOTS = build_roots();

endpackage

>>> src/cdl_slope_offset_power_grade.sv
// top level of the per-pixel slope/offset/power color grade
// throughput: one pixel per cycle while o_stall is low; three channel lanes run side by side, each
//   a 24-stage pipeline whose exp2 part takes one root multiply per stage
// o_stall is the skid-stage full flag, so it is registered and independent of i_valid
// reset (i_rst_n low, synchronous): pipeline and output emptied, slope and power
//   back to 1.0 on all channels, offset back to 0
module cdl_slope_offset_power_grade (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel in
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [cdl_pkg::SAMPLE_BITS-1:0] i_in_red,
    input  logic [cdl_pkg::SAMPLE_BITS-1:0] i_in_green,
    input  logic [cdl_pkg::SAMPLE_BITS-1:0] i_in_blue,
    // pixel out
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [cdl_pkg::SAMPLE_BITS-1:0] o_out_red,
    output logic [cdl_pkg::SAMPLE_BITS-1:0] o_out_green,
    output logic [cdl_pkg::SAMPLE_BITS-1:0] o_out_blue,
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cdl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cdl_pkg::CFG_W-1:0]       i_cfg_data
);
    import cdl_pkg::*;

    // per-channel coefficients, blue in the top lane
    logic [CFG_W-1:0] r_slope;
    logic [CFG_W-1:0] r_offset;
    logic [CFG_W-1:0] r_power;

    logic                   en;
    logic [SAMPLE_BITS-1:0] samples [NUM_LANES];
    t_lane_out              lane_res [NUM_LANES];
    t_pixel                 out_px;

    // registers are always writable; the user must write them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope  <= CFG_UNITY;
            r_offset <= '0;
            r_power  <= CFG_UNITY;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SLOPE:  r_slope  <= i_cfg_data;
                REG_OFFSET: r_offset <= i_cfg_data;
                REG_POWER:  r_power  <= i_cfg_data;
                default:    ;  // unused index, write dropped
            endcase
        end
    end

    // input side stalls only while the skid stage is occupied
    assign o_stall = !en;

    assign samples[0] = i_in_red;
    assign samples[1] = i_in_green;
    assign samples[2] = i_in_blue;

    // one lane per channel, all advancing together
    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        cdl_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (i_valid),
            .i_sample (samples[c]),
            .i_slope  (r_slope[c*COEF_W +: COEF_W]),
            .i_offset (r_offset[c*COEF_W +: COEF_W]),
            .i_power  (r_power[c*COEF_W +: COEF_W]),
            .o_res    (lane_res[c])
        );
    end

    // lane results meet here; output register plus one skid entry
    cdl_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lane  (lane_res),
        .i_stall (i_stall),
        .o_en    (en),
        .o_valid (o_valid),
        .o_pixel (out_px)
    );

    assign o_out_red   = out_px[0];
    assign o_out_green = out_px[1];
    assign o_out_blue  = out_px[2];

endmodule

>>> src/cdl_lane.sv
// one color channel: slope/offset, log2, power multiply, exp2 and rounding
module cdl_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [cdl_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [cdl_pkg::COEF_W-1:0]      i_slope,
    input  logic [cdl_pkg::COEF_W-1:0]      i_offset,
    input  logic [cdl_pkg::COEF_W-1:0]      i_power,
    output cdl_pkg::t_lane_out              o_res
);
    import cdl_pkg::*;

    logic [COEF_W-1:0] slope_eff;
    logic [COEF_W-1:0] power_eff;

    // stage 1: scale
    logic                     r1_v;
    logic [PROD_W-1:0]        r1_prod;
    logic signed [COEF_W-1:0] r1_off;
    // stage 2: add offset
    logic                     r2_v;
    logic                     r2_pos;
    logic [B_W-1:0]           r2_b;
    // stage 3: normalize
    logic                     r3_v;
    logic                     r3_pos;
    logic [E_W-1:0]           r3_e;
    logic [LOG_TABLE_ADDR_BITS-1:0] r3_idx;
    logic [REM_BITS-1:0]      r3_rem;
    // stage 4: table read
    logic                     r4_v;
    logic                     r4_pos;
    logic [E_W-1:0]           r4_e;
    logic [LOG_ENT_W-1:0]     r4_ent;
    logic [REM_BITS-1:0]      r4_rem;
    // stage 5: interpolate
    logic                     r5_v;
    logic                     r5_pos;
    logic [E_W-1:0]           r5_e;
    logic [LOG_FRAC-1:0]      r5_l0;
    logic [IP_W-1:0]          r5_ip;
    // stage 6: times power
    logic                     r6_v;
    logic                     r6_pos;
    logic signed [LP_W-1:0]   r6_lp;
    // exp2 steps, index 0 is the entry of the chain
    logic                     r_v    [EXP_STEPS+1];
    logic [Y_W-1:0]           r_y    [EXP_STEPS+1];
    logic [LOG_FRAC-1:0]      r_f    [EXP_STEPS+1];
    logic [SH_W-1:0]          r_sh   [EXP_STEPS+1];
    t_mode                    r_mode [EXP_STEPS+1];
    logic                     r_res_valid;
    logic [SAMPLE_BITS-1:0]   r_res_value;

    logic signed [SUM_W-1:0]  sum;
    logic [E_W-1:0]           lead;
    logic [MSH_W-1:0]         mshift;
    logic [Y_W-1:0]           mant;
    logic signed [LG_W-1:0]   e_term;
    logic signed [LG_W-1:0]   lg;
    logic signed [T_W-1:0]    t_val;
    logic signed [N_W-1:0]    n_val;
    logic signed [SHF_W-1:0]  sh_full;
    t_mode                    mode0;
    logic [2*Y_W-1:0]         ex_prod [EXP_STEPS];
    logic [RS_W-1:0]          rsum;
    logic [RS_W-1:0]          rq;
    logic [SAMPLE_BITS-1:0]   calc_val;

    assign slope_eff = (i_slope == '0) ? COEF_W'(1) : i_slope;
    assign power_eff = (i_power == '0) ? COEF_W'(1) : i_power;

    always_comb begin
        sum  = $signed({2'b00, r1_prod}) + (SUM_W'(r1_off) <<< FRAC);
        lead = '0;
        for (int i = 0; i < B_W; i++) begin
            if (r2_b[i]) begin
                lead = E_W'(i);
            end
        end
        mshift = {r2_b, MANT'(0)} >> lead;
        mant   = mshift[Y_W-1:0];
    end

    always_comb begin
        e_term = (LG_W'($signed({1'b0, r5_e})) - LG_W'(FRAC + COEF_FRAC)) <<< LOG_FRAC;
        lg     = LG_W'($signed({1'b0, r5_l0})) + LG_W'(r5_ip >> REM_BITS) + e_term;
        t_val  = T_W'(r6_lp >>> COEF_FRAC);
        n_val  = N_W'(t_val >>> LOG_FRAC);
        sh_full = SHF_W'(MANT - FRAC) - SHF_W'(n_val);
        if (!r6_pos) begin
            mode0 = MODE_ZERO;
        end else if (!t_val[T_W-1]) begin
            mode0 = MODE_ONE;
        end else if (sh_full > SHF_W'(Y_W)) begin
            mode0 = MODE_ZERO;
        end else begin
            mode0 = MODE_CALC;
        end
    end

    always_comb begin
        for (int j = 0; j < EXP_STEPS; j++) begin
            ex_prod[j] = (2*Y_W)'(r_y[j]) * (2*Y_W)'(EXP_ROOTS[j]);
        end
        rsum = RS_W'(r_y[EXP_STEPS])
             + (RS_W'(1) << (r_sh[EXP_STEPS] - SH_W'(1)));
        rq   = rsum >> r_sh[EXP_STEPS];
        calc_val = (rq > RS_W'(ONE_SAMPLE)) ? ONE_SAMPLE : rq[SAMPLE_BITS-1:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            for (int j = 0; j <= EXP_STEPS; j++) begin
                r_v[j] <= 1'b0;
            end
            r_res_valid <= 1'b0;
        end else if (i_en) begin
            r1_v   <= i_valid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r4_v   <= r3_v;
            r5_v   <= r4_v;
            r6_v   <= r5_v;
            r_v[0] <= r6_v;
            for (int j = 0; j < EXP_STEPS; j++) begin
                r_v[j+1] <= r_v[j];
            end
            r_res_valid <= r_v[EXP_STEPS];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= PROD_W'(i_sample) * PROD_W'(slope_eff);
            r1_off  <= i_offset;

            r2_pos  <= (sum > 0);
            r2_b    <= sum[B_W-1:0];

            r3_pos  <= r2_pos;
            r3_e    <= lead;
            r3_idx  <= mant[MANT-1 -: LOG_TABLE_ADDR_BITS];
            r3_rem  <= mant[REM_BITS-1:0];

            r4_pos  <= r3_pos;
            r4_e    <= r3_e;
            r4_ent  <= LOG_ROM[r3_idx];
            r4_rem  <= r3_rem;

            r5_pos  <= r4_pos;
            r5_e    <= r4_e;
            r5_l0   <= r4_ent[LOG_ENT_W-1 -: LOG_FRAC];
            r5_ip   <= IP_W'(r4_ent[DL_W-1:0]) * IP_W'(r4_rem);

            r6_pos  <= r5_pos;
            r6_lp   <= LP_W'(lg) * LP_W'($signed({1'b0, power_eff}));

            r_y[0]    <= ONE_MANT;
            r_f[0]    <= t_val[LOG_FRAC-1:0];
            r_sh[0]   <= sh_full[SH_W-1:0];
            r_mode[0] <= mode0;
            for (int j = 0; j < EXP_STEPS; j++) begin
                r_y[j+1]    <= r_f[j][LOG_FRAC-1-j] ? ex_prod[j][MANT +: Y_W] : r_y[j];
                r_f[j+1]    <= r_f[j];
                r_sh[j+1]   <= r_sh[j];
                r_mode[j+1] <= r_mode[j];
            end

            case (r_mode[EXP_STEPS])
                MODE_ONE:  r_res_value <= ONE_SAMPLE;
                MODE_CALC: r_res_value <= calc_val;
                default:   r_res_value <= '0;
            endcase
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.value = r_res_value;

endmodule

>>> src/cdl_merge.sv
// joins the three lane results into one pixel, with output register and skid stage
module cdl_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cdl_pkg::t_lane_out              i_lane [cdl_pkg::NUM_LANES],
    input  logic                            i_stall,
    output logic                            o_en,
    output logic                            o_valid,
    output cdl_pkg::t_pixel                 o_pixel
);
    import cdl_pkg::*;

    logic   r_out_valid;
    logic   r_skid_valid;
    t_pixel r_out_px;
    t_pixel r_skid_px;
    t_pixel lane_px;
    logic   lane_valid;

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            lane_px[c] = i_lane[c].value;
        end
        lane_valid = i_lane[0].valid;
    end

    assign o_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && i_stall) begin
            if (!r_skid_valid && lane_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= lane_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && i_stall) begin
            if (!r_skid_valid) begin
                r_skid_px <= lane_px;
            end
        end else if (r_skid_valid) begin
            r_out_px <= r_skid_px;
        end else begin
            r_out_px <= lane_px;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_px;

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_lane[0].valid == i_lane[1].valid) && (i_lane[0].valid == i_lane[2].valid))
        else $error("lane valid bits disagree");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while output is empty");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled item dropped");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_px[0] <= ONE_SAMPLE) && (r_out_px[1] <= ONE_SAMPLE)
                         && (r_out_px[2] <= ONE_SAMPLE)))
        else $error("output above 1.0");

endmodule
